// ===== src/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear blend skinning package
// Shared sizes, types and request codes of the skinning core.
// ----------------------------------------------------------------------------
package lbs_pkg;

  // Palette and influence sizes.
  localparam int MaxBones   = 256;
  localparam int Influences = 4;
  localparam int NumInf     = (Influences < 4) ? Influences : 4;
  localparam int BoneW      = $clog2(MaxBones);

  // Matrix rows that produce a result, and columns per row.
  localparam int Rows = 3;
  localparam int Cols = 4;

  // Widths of the datapath.
  localparam int ProdW = 64;   // element times coordinate, Q32.32
  localparam int SumW  = 66;   // one matrix row times the vertex
  localparam int TermW = 83;   // row sum times Q1.15 weight
  localparam int AccW  = 85;   // sum over four influences
  localparam int NumStages = 8;

  // Request kinds carried on tuser.
  typedef enum logic {
    FuncLoad = 1'b0,
    FuncSkin = 1'b1
  } lbs_func_e;

  typedef logic signed [31:0] lbs_word_t;
  typedef lbs_word_t [Rows-1:0][Cols-1:0] lbs_mat_t;
  typedef lbs_word_t [Rows-1:0] lbs_vec_t;
  typedef logic signed [TermW-1:0] lbs_term_t;
  typedef lbs_term_t [Rows-1:0] lbs_terms_t;

  // Stage advance strobes seen by one influence lane.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } lbs_adv_t;

endpackage

// ===== src/lbs_palette.sv =====
// ----------------------------------------------------------------------------
// Bone palette copy
// One copy of the palette for one influence, split in twelve banks so that
// the three used rows of a bone matrix are read at once.
// ----------------------------------------------------------------------------
module lbs_palette (
  input  logic                   clk_i,
  input  logic                   wr_en_i,
  input  logic [lbs_pkg::BoneW-1:0] wr_bone_i,
  input  logic [3:0]             wr_elem_i,
  input  lbs_pkg::lbs_word_t     wr_data_i,
  input  logic                   rd_en_i,
  input  logic [lbs_pkg::BoneW-1:0] rd_bone_i,
  output lbs_pkg::lbs_mat_t      rd_mat_o
);

  // Element index is column times four plus row.
  logic [1:0] wr_row;
  logic [1:0] wr_col;
  assign wr_row = wr_elem_i[1:0];
  assign wr_col = wr_elem_i[3:2];

  for (genvar r = 0; r < lbs_pkg::Rows; r++) begin : g_row
    for (genvar c = 0; c < lbs_pkg::Cols; c++) begin : g_col
      lbs_pkg::lbs_word_t mem [lbs_pkg::MaxBones];
      lbs_pkg::lbs_word_t rd_q;

      // Write port: one element of one bone.
      always_ff @(posedge clk_i) begin
        if (wr_en_i && (wr_row == 2'(r)) && (wr_col == 2'(c))) begin
          mem[wr_bone_i] <= wr_data_i;
        end
      end

      // Registered read port.
      always_ff @(posedge clk_i) begin
        if (rd_en_i) begin
          rd_q <= mem[rd_bone_i];
        end
      end

      assign rd_mat_o[r][c] = rd_q;
    end
  end

endmodule

// ===== src/lbs_lane.sv =====
// ----------------------------------------------------------------------------
// Skinning influence lane
// Multiplies one bone matrix by the vertex, sums each row and scales the
// row sums by the influence weight over four register stages.
// ----------------------------------------------------------------------------
module lbs_lane (
  input  logic               clk_i,
  input  lbs_pkg::lbs_adv_t  adv_i,
  input  lbs_pkg::lbs_mat_t  mat_i,
  input  lbs_pkg::lbs_vec_t  pos_i,
  input  logic [15:0]        weight_i,
  input  logic               bone_ok_i,
  output lbs_pkg::lbs_terms_t term_o
);

  logic signed [lbs_pkg::ProdW-1:0] prod_q [lbs_pkg::Rows][3];
  lbs_pkg::lbs_word_t               m3_q   [lbs_pkg::Rows];
  logic signed [lbs_pkg::SumW-1:0]  sum_q  [lbs_pkg::Rows];
  logic [48:0]                      lo_q   [lbs_pkg::Rows];
  logic signed [49:0]               hi_q   [lbs_pkg::Rows];
  lbs_pkg::lbs_term_t               term_q [lbs_pkg::Rows];
  logic [15:0] w2_q, w3_q;
  logic        ok2_q;

  // Stage 2: element times coordinate products.
  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      for (int r = 0; r < lbs_pkg::Rows; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= mat_i[r][c] * pos_i[c];
        end
        m3_q[r] <= mat_i[r][3];
      end
      w2_q  <= weight_i;
      ok2_q <= bone_ok_i;
    end
  end

  // Stage 3: row sums; the w coordinate is one, a shift by sixteen.
  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      for (int r = 0; r < lbs_pkg::Rows; r++) begin
        if (ok2_q) begin
          sum_q[r] <= lbs_pkg::SumW'(prod_q[r][0]) + lbs_pkg::SumW'(prod_q[r][1])
                    + lbs_pkg::SumW'(prod_q[r][2])
                    + (lbs_pkg::SumW'(m3_q[r]) <<< 16);
        end else begin
          sum_q[r] <= '0;
        end
      end
      w3_q <= w2_q;
    end
  end

  // Stage 4: weight products, split in a low and a high half.
  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      for (int r = 0; r < lbs_pkg::Rows; r++) begin
        lo_q[r] <= 49'(sum_q[r][32:0]) * 49'(w3_q);
        hi_q[r] <= $signed(sum_q[r][65:33]) * $signed({1'b0, w3_q});
      end
    end
  end

  // Stage 5: join the halves into the weighted term.
  always_ff @(posedge clk_i) begin
    if (adv_i.s5) begin
      for (int r = 0; r < lbs_pkg::Rows; r++) begin
        term_q[r] <= (lbs_pkg::TermW'(hi_q[r]) <<< 33) + lbs_pkg::TermW'(lo_q[r]);
      end
    end
  end

  for (genvar r = 0; r < lbs_pkg::Rows; r++) begin : g_out
    assign term_o[r] = term_q[r];
  end

endmodule

// ===== src/linear_blend_skinning_core.sv =====
// ----------------------------------------------------------------------------
// Linear blend skinning core
// Four-influence vertex skinning with a palette of 4x4 Q16.16 bone matrices.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  s_axis   in         load request (tuser 0) or skin request (tuser 1)
//  m_axis   out        skinned x, y, z, one per skin request
//
//  A request can enter every cycle while the first stage can advance. A skin
//  request passes the eight-stage pipeline: palette read, products, row sums,
//  weight products, weighted terms, pair sums, rounding, saturation. A load
//  request writes the palette banks at its acceptance.
//  Reset clears only the valid bits; the palette holds nothing defined until
//  loaded. A stalled output holds the pipeline stage by stage, and empty
//  stages still fill, so requests are taken while a result waits, as long as a stage is empty.
module linear_blend_skinning_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // load_bone, load_element, load_value, pos_x, pos_y, pos_z,
  // bone_indices_packed, weight_a, weight_b, weight_c, weight_d, zero pad
  input  logic [239:0] s_axis_tdata,
  // func
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x, out_y, out_z
  output logic [95:0]  m_axis_tdata
);

  localparam int N = lbs_pkg::NumStages;

  // Request fields.
  logic [7:0]         load_bone;
  logic [3:0]         load_element;
  lbs_pkg::lbs_word_t load_value;
  lbs_pkg::lbs_vec_t  pos;
  logic [31:0]        bone_indices_packed;
  logic [15:0]        weight [4];

  assign load_bone           = s_axis_tdata[7:0];
  assign load_element        = s_axis_tdata[11:8];
  assign load_value          = s_axis_tdata[43:12];
  assign pos[0]              = s_axis_tdata[75:44];
  assign pos[1]              = s_axis_tdata[107:76];
  assign pos[2]              = s_axis_tdata[139:108];
  assign bone_indices_packed = s_axis_tdata[171:140];
  assign weight[0]           = s_axis_tdata[187:172];
  assign weight[1]           = s_axis_tdata[203:188];
  assign weight[2]           = s_axis_tdata[219:204];
  assign weight[3]           = s_axis_tdata[235:220];

  // Valid bits and per-stage ready chain.
  logic [N:1]   valid_q, valid_d;
  logic [N+1:1] rdy;
  logic         req_acc, load_acc, skin_acc, load_ok;

  always_comb begin
    rdy[N+1] = m_axis_tready;
    for (int k = N; k >= 1; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[1];
  assign req_acc  = s_axis_tvalid && s_axis_tready;
  assign load_acc = req_acc && (s_axis_tuser == lbs_pkg::FuncLoad);
  assign skin_acc = req_acc && (s_axis_tuser == lbs_pkg::FuncSkin);
  assign load_ok  = 32'(load_bone) < lbs_pkg::MaxBones;

  always_comb begin
    valid_d = valid_q;
    if (rdy[1]) begin
      valid_d[1] = skin_acc;
    end
    for (int k = 2; k <= N; k++) begin
      if (rdy[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Stage 1 side registers: vertex, weights and index checks.
  lbs_pkg::lbs_vec_t pos1_q;
  logic [15:0]       w1_q  [lbs_pkg::NumInf];
  logic              ok1_q [lbs_pkg::NumInf];

  lbs_pkg::lbs_adv_t lane_adv;
  assign lane_adv.s2 = rdy[2];
  assign lane_adv.s3 = rdy[3];
  assign lane_adv.s4 = rdy[4];
  assign lane_adv.s5 = rdy[5];

  lbs_pkg::lbs_terms_t term [4];

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      pos1_q <= pos;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_inf
    if (i < lbs_pkg::NumInf) begin : g_used
      logic [7:0]        bone;
      lbs_pkg::lbs_mat_t mat;

      assign bone = bone_indices_packed[8*i +: 8];

      always_ff @(posedge clk_i) begin
        if (rdy[1]) begin
          w1_q[i]  <= weight[i];
          ok1_q[i] <= 32'(bone) < lbs_pkg::MaxBones;
        end
      end

      lbs_palette u_palette (
        .clk_i     (clk_i),
        .wr_en_i   (load_acc && load_ok),
        .wr_bone_i (lbs_pkg::BoneW'(load_bone)),
        .wr_elem_i (load_element),
        .wr_data_i (load_value),
        .rd_en_i   (rdy[1]),
        .rd_bone_i (lbs_pkg::BoneW'(bone)),
        .rd_mat_o  (mat)
      );

      lbs_lane u_lane (
        .clk_i     (clk_i),
        .adv_i     (lane_adv),
        .mat_i     (mat),
        .pos_i     (pos1_q),
        .weight_i  (w1_q[i]),
        .bone_ok_i (ok1_q[i]),
        .term_o    (term[i])
      );
    end else begin : g_unused
      assign term[i] = '0;
    end
  end

  // Stages 6 to 8: pair sums, total with rounding bias, shift and saturate.
  logic signed [lbs_pkg::AccW-1:0] pa_q  [lbs_pkg::Rows];
  logic signed [lbs_pkg::AccW-1:0] pb_q  [lbs_pkg::Rows];
  logic signed [lbs_pkg::AccW-1:0] acc_q [lbs_pkg::Rows];
  lbs_pkg::lbs_word_t              out_q [lbs_pkg::Rows];
  logic signed [lbs_pkg::AccW-32:0] shifted [lbs_pkg::Rows];

  localparam logic signed [lbs_pkg::AccW-1:0] RoundBias = lbs_pkg::AccW'(64'd1 << 30);

  always_comb begin
    for (int r = 0; r < lbs_pkg::Rows; r++) begin
      shifted[r] = acc_q[r][lbs_pkg::AccW-1:31];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < lbs_pkg::Rows; r++) begin
      if (rdy[6]) begin
        pa_q[r] <= lbs_pkg::AccW'(term[0][r]) + lbs_pkg::AccW'(term[1][r]);
        pb_q[r] <= lbs_pkg::AccW'(term[2][r]) + lbs_pkg::AccW'(term[3][r]);
      end
      if (rdy[7]) begin
        acc_q[r] <= pa_q[r] + pb_q[r] + RoundBias;
      end
      if (rdy[8]) begin
        if (shifted[r] > $signed(54'sh7FFFFFFF)) begin
          out_q[r] <= 32'sh7FFFFFFF;
        end else if (shifted[r] < -$signed(54'sh80000000)) begin
          out_q[r] <= 32'sh80000000;
        end else begin
          out_q[r] <= shifted[r][31:0];
        end
      end
    end
  end

  assign m_axis_tvalid = valid_q[N];
  assign m_axis_tdata  = {out_q[2], out_q[1], out_q[0]};

  // A full input side means the first stage holds a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> valid_q[1])
    else $error("input stalled with an empty first stage");

  // An accepted skin request enters the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skin_acc |=> valid_q[1])
    else $error("skin request not captured");

  // While the output stalls, no request is dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      ($countones(valid_q) >= $past($countones(valid_q))))
    else $error("request lost during output stall");

endmodule
